### hdl/start_length_xor_frame_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef START_LENGTH_XOR_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define START_LENGTH_XOR_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sld_pkg.sv
// Shared constants, types and state encoding of the frame deframer.
package sld_pkg;

	localparam int MAX_DATA = 60;
	localparam int WIN      = MAX_DATA + 4;
	localparam int HDR      = 3;
	localparam int AW       = 6;
	localparam int FILL_W   = 7;

	localparam logic [7:0] START_RESET = 8'h5B;

	// Request side of one simple dual-port RAM
	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [7:0]    wdata;
		logic [AW-1:0] raddr;
	} ram_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_FIN,
		ST_CMD_RD,
		ST_CMD_CAP,
		ST_DAT_RD,
		ST_DAT_CAP,
		ST_EMPTY
	} sld_state_t;

endpackage

### hdl/sld_if.sv
// Valid/ready channel interfaces: received bytes, marker writes, frame results.
interface sld_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] start_marker;

	modport source (output valid, output start_marker, input ready);
	modport sink (input valid, input start_marker, output ready);
endinterface

interface sld_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] command_code;
	logic [5:0] data_length;
	logic       data_present;
	logic [7:0] data_value;
	logic [5:0] data_position;
	logic       last_of_frame;

	modport source (
		output valid, output command_code, output data_length, output data_present,
		output data_value, output data_position, output last_of_frame, input ready
	);
	modport sink (
		input valid, input command_code, input data_length, input data_present,
		input data_value, input data_position, input last_of_frame, output ready
	);
endinterface

### hdl/start_length_xor_frame_deframer_core.sv
// Top level of the start/length/XOR frame deframer.
//
//   channel  modport  payload                                   transfer when
//   rx       sink     rx_byte                                   valid && ready
//   cfg      sink     start_marker                              valid && ready
//   res      source   command_code, data_length, data_present,  valid && ready
//                     data_value, data_position, last_of_frame
//
// A byte with p (1..63) bytes held is taken, walked over the byte and XOR RAMs, then the
// window is trimmed; the walk is skipped when the window is empty or full.
// A byte that closes a frame starting at entry s ends the walk at s, then the command is read
// and captured, then each data result is read and captured (one result for an empty frame).
// Reset clears the candidate flags at once; RAM contents need no clearing pass.
// rx waits during walk and emission; res stalls hold the sequencer; cfg is always ready.
`include "start_length_xor_frame_deframer_core_defines.svh"

module start_length_xor_frame_deframer_core (
	input  logic      clk,
	input  logic      arst_n,
	sld_rx_if.sink    rx,
	sld_cfg_if.sink   cfg,
	sld_res_if.source res
);

	import sld_pkg::*;

	logic [7:0] marker_q;
	ram_req_t   win_req;
	ram_req_t   xor_req;
	logic [7:0] win_rdata;
	logic [7:0] xor_rdata;

	// Start marker register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= START_RESET;
		end else if (cfg.valid && cfg.ready) begin
			marker_q <= cfg.start_marker;
		end
	end

	// Received bytes of the window
	sld_ram #(.WIDTH(8), .DEPTH(WIN)) u_win_ram (
		.clk   (clk),
		.we    (win_req.we),
		.waddr (win_req.waddr),
		.wdata (win_req.wdata),
		.raddr (win_req.raddr),
		.rdata (win_rdata)
	);

	// Running XOR per candidate start
	sld_ram #(.WIDTH(8), .DEPTH(WIN)) u_xor_ram (
		.clk   (clk),
		.we    (xor_req.we),
		.waddr (xor_req.waddr),
		.wdata (xor_req.wdata),
		.raddr (xor_req.raddr),
		.rdata (xor_rdata)
	);

	sld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.marker    (marker_q),
		.rx        (rx),
		.res       (res),
		.win_req   (win_req),
		.win_rdata (win_rdata),
		.xor_req   (xor_req),
		.xor_rdata (xor_rdata)
	);

	// Checks
	`SLD_ASSERT_IMP(a_win_write_on_rx, win_req.we, rx.valid && rx.ready, "window write without rx transfer")
	`SLD_ASSERT_NXT(a_busy_after_rx, rx.valid && rx.ready, !rx.ready, "rx ready right after a transfer")
	`SLD_ASSERT_IMP(a_empty_frame, res.valid && !res.data_present, res.last_of_frame && res.data_length == 6'd0, "empty frame result malformed")
	`SLD_ASSERT_IMP(a_pos_range, res.valid && res.data_present, res.data_position < res.data_length, "data position beyond length")

endmodule

### hdl/sld_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/sld_ctrl.sv
// Sequencer: candidate walk over the window RAMs, window trim, frame emission.
module sld_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        marker,
	sld_rx_if.sink            rx,
	sld_res_if.source         res,
	output sld_pkg::ram_req_t win_req,
	input  logic [7:0]        win_rdata,
	output sld_pkg::ram_req_t xor_req,
	input  logic [7:0]        xor_rdata
);

	import sld_pkg::*;

	sld_state_t state_q, state_d;

	// Window bookkeeping: circular buffer starting at base_q
	logic [FILL_W-1:0] fill_q;
	logic [AW-1:0]     base_q;
	logic [WIN-1:0]    live_q;

	// Current item
	logic [7:0]    b_q;
	logic          mark_q;
	logic [AW-1:0] p_q;

	// Walk issue counter and compare stage
	logic [AW-1:0] iss_q;
	logic          vld_s1;
	logic [AW-1:0] a_s1;
	logic [AW-1:0] s_s1;
	logic          surv_q;
	logic [AW-1:0] first_q;

	// Emission
	logic [AW-1:0] acc_q;
	logic [5:0]    len_q;
	logic [5:0]    k_q;
	logic [7:0]    cmd_q;

	// Output register
	logic       ovld_q;
	logic [7:0] o_cmd_q;
	logic [5:0] o_len_q;
	logic       o_pres_q;
	logic [7:0] o_val_q;
	logic [5:0] o_pos_q;
	logic       o_last_q;

	logic           accept;
	logic [AW-1:0]  p_next;
	logic [AW-1:0]  p_phys;
	logic           is_mark;
	logic [WIN-1:0] live_acc;
	logic           issue;
	logic           out_free;
	logic           load_dat;
	logic           load_empty;
	logic           walk_done;
	logic [AW-1:0]  trim;

	// Compare stage results
	logic [AW-1:0] d_s1;
	logic          live_s1;
	logic          kill_s1;
	logic          upd_s1;
	logic          match_s1;
	logic          found_s1;
	logic          surv_s1;

	assign rx.ready = (state_q == ST_IDLE);
	assign accept   = rx.valid && rx.ready;
	assign p_next   = fill_q[FILL_W-1] ? '0 : fill_q[AW-1:0];
	assign p_phys   = base_q + p_next;
	assign is_mark  = (rx.rx_byte == marker);
	assign out_free = !ovld_q || res.ready;

	// Live flags on arrival: a full window is flushed, a marker opens a candidate
	always_comb begin
		live_acc = fill_q[FILL_W-1] ? '0 : live_q;
		if (is_mark) begin
			live_acc[p_phys] = 1'b1;
		end
	end

	// Candidate update for the entry in the compare stage
	always_comb begin
		d_s1     = p_q - s_s1;
		live_s1  = live_q[a_s1];
		kill_s1  = 1'b0;
		upd_s1   = 1'b0;
		match_s1 = 1'b0;
		if (d_s1 == AW'(1)) begin
			upd_s1 = 1'b1;
		end else if (d_s1 == AW'(2)) begin
			kill_s1 = (b_q > 8'(MAX_DATA));
			upd_s1  = !kill_s1;
		end else if ({3'b000, d_s1} >= ({1'b0, win_rdata} + 9'(HDR))) begin
			match_s1 = ({3'b000, d_s1} == ({1'b0, win_rdata} + 9'(HDR)))
				&& (xor_rdata == b_q);
			kill_s1  = 1'b1;
		end else begin
			upd_s1 = 1'b1;
		end
		found_s1 = vld_s1 && live_s1 && match_s1;
		surv_s1  = vld_s1 && live_s1 && !kill_s1;
	end

	assign walk_done = vld_s1 && (s_s1 == p_q - AW'(1));
	assign trim      = surv_q ? first_q : p_q;

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		load_dat   = 1'b0;
		load_empty = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (p_next == '0) ? ST_FIN : ST_WALK;
				end
			end
			ST_WALK: begin
				issue = (iss_q < p_q);
				if (found_s1) begin
					state_d = ST_CMD_RD;
				end else if (walk_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			ST_CMD_RD: begin
				state_d = ST_CMD_CAP;
			end
			ST_CMD_CAP: begin
				state_d = (len_q == '0) ? ST_EMPTY : ST_DAT_RD;
			end
			ST_DAT_RD: begin
				if (out_free) begin
					state_d = ST_DAT_CAP;
				end
			end
			ST_DAT_CAP: begin
				load_dat = 1'b1;
				state_d  = (k_q == len_q - 6'd1) ? ST_IDLE : ST_DAT_RD;
			end
			ST_EMPTY: begin
				if (out_free) begin
					load_empty = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// RAM requests
	always_comb begin
		win_req.we    = accept;
		win_req.waddr = p_phys;
		win_req.wdata = rx.rx_byte;
		case (state_q)
			ST_WALK:   win_req.raddr = base_q + iss_q + AW'(2);
			ST_CMD_RD: win_req.raddr = acc_q + AW'(1);
			default:   win_req.raddr = acc_q + AW'(HDR) + k_q;
		endcase

		xor_req.raddr = base_q + iss_q;
		if (accept) begin
			xor_req.we    = 1'b1;
			xor_req.waddr = p_phys;
			xor_req.wdata = rx.rx_byte;
		end else begin
			xor_req.we    = (state_q == ST_WALK) && vld_s1 && live_s1 && upd_s1;
			xor_req.waddr = a_s1;
			xor_req.wdata = xor_rdata ^ b_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window, walk and emission registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			base_q <= '0;
			live_q <= '0;
			iss_q  <= '0;
			vld_s1 <= 1'b0;
			surv_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (accept) begin
				b_q    <= rx.rx_byte;
				mark_q <= is_mark;
				p_q    <= p_next;
				fill_q <= {1'b0, p_next} + FILL_W'(1);
				live_q <= live_acc;
				iss_q  <= '0;
				surv_q <= 1'b0;
			end
			if (state_q == ST_WALK) begin
				vld_s1 <= issue && !found_s1;
				if (issue) begin
					a_s1  <= base_q + iss_q;
					s_s1  <= iss_q;
					iss_q <= iss_q + AW'(1);
				end
				if (found_s1) begin
					acc_q  <= a_s1;
					len_q  <= win_rdata[5:0];
					k_q    <= '0;
					live_q <= '0;
					fill_q <= '0;
				end else if (vld_s1 && live_s1 && kill_s1) begin
					live_q[a_s1] <= 1'b0;
				end
				if (surv_s1 && !surv_q) begin
					surv_q  <= 1'b1;
					first_q <= s_s1;
				end
			end
			// Trim to the earliest pending candidate, or empty the window
			if (state_q == ST_FIN) begin
				if (surv_q || mark_q) begin
					base_q <= base_q + trim;
					fill_q <= {1'b0, p_q} + FILL_W'(1) - {1'b0, trim};
				end else begin
					fill_q <= '0;
					live_q <= '0;
				end
			end
			if (state_q == ST_CMD_CAP) begin
				cmd_q <= win_rdata;
			end
			if (load_dat) begin
				k_q <= k_q + 6'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_dat || load_empty) begin
			ovld_q <= 1'b1;
		end else if (res.ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_dat) begin
			o_cmd_q  <= cmd_q;
			o_len_q  <= len_q;
			o_pres_q <= 1'b1;
			o_val_q  <= win_rdata;
			o_pos_q  <= k_q;
			o_last_q <= (k_q == len_q - 6'd1);
		end else if (load_empty) begin
			o_cmd_q  <= cmd_q;
			o_len_q  <= '0;
			o_pres_q <= 1'b0;
			o_val_q  <= '0;
			o_pos_q  <= '0;
			o_last_q <= 1'b1;
		end
	end

	assign res.valid         = ovld_q;
	assign res.command_code  = o_cmd_q;
	assign res.data_length   = o_len_q;
	assign res.data_present  = o_pres_q;
	assign res.data_value    = o_val_q;
	assign res.data_position = o_pos_q;
	assign res.last_of_frame = o_last_q;

endmodule
